FILE: src/mersenne_twister_bounded_random_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bounded MT19937 generator.
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_BOUNDED_RANDOM_TOP_MACROS_SVH
`define MERSENNE_TWISTER_BOUNDED_RANDOM_TOP_MACROS_SVH

// same-cycle implication
`define MTBR_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("mtbr assertion failed");

// next-cycle implication
`define MTBR_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("mtbr assertion failed");

`endif

FILE: src/mtbr_pkg.sv
// ----------------------------------------------------------------------------
// mtbr_pkg
// Constants, state type and tempering function of the bounded MT19937 block.
// ----------------------------------------------------------------------------
package mtbr_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;

    localparam logic [31:0] SEED_RESET   = 32'd4357;
    localparam logic [31:0] FILL_MULT    = 32'd69069;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_RD_CUR,
        ST_RD_NEXT,
        ST_RD_FAR,
        ST_TWIST,
        ST_DIV,
        ST_DONE
    } state_t;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

FILE: src/mtbr_in_if.sv
// ----------------------------------------------------------------------------
// mtbr_in_if
// Request channel: valid, ready and the exclusive upper bound.
// ----------------------------------------------------------------------------
interface mtbr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] range_bound;

    modport source (output valid, output range_bound, input ready);
    modport sink   (input valid, input range_bound, output ready);
endinterface

FILE: src/mtbr_out_if.sv
// ----------------------------------------------------------------------------
// mtbr_out_if
// Result channel: valid, ready and the bounded random word.
// ----------------------------------------------------------------------------
interface mtbr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

FILE: src/mtbr_ram.sv
// ----------------------------------------------------------------------------
// mtbr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: src/mersenne_twister_bounded_random_top.sv
// ----------------------------------------------------------------------------
// mersenne_twister_bounded_random_top
// Bounded MT19937 generator: twist on use, temper, serial modulo by bound.
// ----------------------------------------------------------------------------
// A nonzero bound runs from acceptance through three reads of the state RAM
// on its single read port, one twist-and-temper step, a one-bit-per-cycle
// restoring remainder over the 32 tempered bits and a load of the output
// register once it is free; a zero bound goes straight to that load and
// returns 0. After reset and after every seed write the state RAM is refilled
// by a sweep of all 624 words (one word a cycle), accepting no request.
`include "mersenne_twister_bounded_random_top_macros.svh"

module mersenne_twister_bounded_random_top #(
    parameter int STATE_WORDS  = mtbr_pkg::STATE_WORDS,
    parameter int TWIST_OFFSET = mtbr_pkg::TWIST_OFFSET
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_we,
    input  logic [31:0] seed_value,
    mtbr_in_if.sink     in_ch,
    mtbr_out_if.source  out_ch
);

    localparam int ADDR_W = $clog2(STATE_WORDS);
    localparam int IDX_W  = $clog2(STATE_WORDS + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);
    localparam logic [ADDR_W-1:0] FAR_WRAP  = ADDR_W'(STATE_WORDS - TWIST_OFFSET);
    localparam logic [ADDR_W-1:0] FAR_ADD   = ADDR_W'(TWIST_OFFSET);
    localparam logic [IDX_W-1:0]  IDX_END   = IDX_W'(STATE_WORDS);

    mtbr_pkg::state_t state_reg, state_next;

    logic [31:0]       fill_word_reg, fill_word_next;
    logic [ADDR_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [31:0]       bound_reg, bound_next;
    logic [31:0]       cur_reg, cur_next;
    logic [31:0]       nxt_reg, nxt_next;
    logic [31:0]       quo_reg, quo_next;
    logic [31:0]       rem_reg, rem_next;
    logic [4:0]        bit_cnt_reg, bit_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_data_reg, out_data_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
    logic [31:0]       ram_wr_data, ram_rd_data;

    logic [31:0] twist_y, twist_v;
    logic [32:0] trial;
    logic [32:0] trial_diff;
    logic        out_free;

    mtbr_ram #(
        .WIDTH(32),
        .DEPTH(STATE_WORDS)
    ) u_state_ram (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign twist_y    = {cur_reg[31], nxt_reg[30:0]};
    assign twist_v    = ram_rd_data ^ (twist_y >> 1)
                        ^ (twist_y[0] ? mtbr_pkg::TWIST_MATRIX : 32'd0);
    assign trial      = {rem_reg, quo_reg[31]};
    assign trial_diff = trial - {1'b0, bound_reg};
    assign out_free   = !out_valid_reg || out_ch.ready;

    assign in_ch.ready         = (state_reg == mtbr_pkg::ST_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.random_value = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        if (seed_we)
        begin
            state_next = mtbr_pkg::ST_FILL;
        end
        else
        begin
            unique case (state_reg)
                mtbr_pkg::ST_FILL:
                    if (fill_cnt_reg == LAST_ADDR) state_next = mtbr_pkg::ST_IDLE;
                mtbr_pkg::ST_IDLE:
                    if (in_ch.valid)
                    begin
                        state_next = (in_ch.range_bound == 32'd0) ? mtbr_pkg::ST_DONE
                                                                  : mtbr_pkg::ST_RD_CUR;
                    end
                mtbr_pkg::ST_RD_CUR:  state_next = mtbr_pkg::ST_RD_NEXT;
                mtbr_pkg::ST_RD_NEXT: state_next = mtbr_pkg::ST_RD_FAR;
                mtbr_pkg::ST_RD_FAR:  state_next = mtbr_pkg::ST_TWIST;
                mtbr_pkg::ST_TWIST:   state_next = mtbr_pkg::ST_DIV;
                mtbr_pkg::ST_DIV:
                    if (bit_cnt_reg == 5'd31) state_next = mtbr_pkg::ST_DONE;
                mtbr_pkg::ST_DONE:
                    if (out_free) state_next = mtbr_pkg::ST_IDLE;
                default: state_next = mtbr_pkg::ST_FILL;
            endcase
        end
    end

    always_comb
    begin
        ram_we      = 1'b0;
        ram_wr_addr = k_reg;
        ram_wr_data = twist_v;
        ram_rd_addr = k_reg;
        unique case (state_reg)
            mtbr_pkg::ST_FILL:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = fill_cnt_reg;
                ram_wr_data = fill_word_reg;
            end
            mtbr_pkg::ST_RD_NEXT:
                ram_rd_addr = (k_reg == LAST_ADDR) ? '0 : k_reg + ADDR_W'(1);
            mtbr_pkg::ST_RD_FAR:
                ram_rd_addr = (k_reg >= FAR_WRAP) ? k_reg - FAR_WRAP : k_reg + FAR_ADD;
            mtbr_pkg::ST_TWIST:
                ram_we = 1'b1;
            default:
                ram_rd_addr = k_reg;
        endcase
    end

    always_comb
    begin
        fill_word_next = fill_word_reg;
        fill_cnt_next  = fill_cnt_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        bound_next     = bound_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_data_next  = out_data_reg;
        if (seed_we)
        begin
            fill_word_next = seed_value;
            fill_cnt_next  = '0;
        end
        else
        begin
            unique case (state_reg)
                mtbr_pkg::ST_FILL:
                begin
                    fill_word_next = 32'(fill_word_reg * mtbr_pkg::FILL_MULT);
                    fill_cnt_next  = fill_cnt_reg + ADDR_W'(1);
                    idx_next       = IDX_END;
                end
                mtbr_pkg::ST_IDLE:
                begin
                    bound_next = in_ch.range_bound;
                    rem_next   = '0;
                    k_next     = (idx_reg == IDX_END) ? '0 : idx_reg[ADDR_W-1:0];
                end
                mtbr_pkg::ST_RD_NEXT: cur_next = ram_rd_data;
                mtbr_pkg::ST_RD_FAR:  nxt_next = ram_rd_data;
                mtbr_pkg::ST_TWIST:
                begin
                    quo_next     = mtbr_pkg::temper(twist_v);
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    idx_next     = IDX_W'(k_reg) + IDX_W'(1);
                end
                mtbr_pkg::ST_DIV:
                begin
                    quo_next     = {quo_reg[30:0], 1'b0};
                    rem_next     = trial_diff[32] ? trial[31:0] : trial_diff[31:0];
                    bit_cnt_next = bit_cnt_reg + 5'd1;
                end
                mtbr_pkg::ST_DONE:
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = rem_reg;
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtbr_pkg::ST_FILL;
            fill_word_reg <= mtbr_pkg::SEED_RESET;
            fill_cnt_reg  <= '0;
            idx_reg       <= IDX_END;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_word_reg <= fill_word_next;
            fill_cnt_reg  <= fill_cnt_next;
            idx_reg       <= idx_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        bound_reg    <= bound_next;
        cur_reg      <= cur_next;
        nxt_reg      <= nxt_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

    `MTBR_ASSERT_NEXT(a_twist_to_div, clk, rst_n,
        (state_reg == mtbr_pkg::ST_TWIST) && !seed_we, state_reg == mtbr_pkg::ST_DIV)
    `MTBR_ASSERT_IMPL(a_rem_below_bound, clk, rst_n,
        state_reg == mtbr_pkg::ST_DIV, rem_reg < bound_reg)
    `MTBR_ASSERT_IMPL(a_idx_in_range, clk, rst_n,
        state_reg != mtbr_pkg::ST_FILL, idx_reg <= IDX_END)

endmodule

FILE: test/tb_mtbr_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench channel helpers
// Interfaces are taken from the RTL; this file only collects shared test
// constants used by the bench.
// ----------------------------------------------------------------------------
package tb_mtbr_test_pkg;

    localparam int FILL_CYCLES    = 624;
    localparam int REQUEST_CYCLES = 37;

endpackage

FILE: test/tb_mersenne_twister_bounded_random_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mersenne_twister_bounded_random_top
// Drives bound requests into the bounded MT19937 generator and checks every
// result against an in-bench twister model, across several seeds including
// zero and all ones, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_mersenne_twister_bounded_random_top;

    logic        clk;
    logic        rst_n;
    logic        seed_we;
    logic [31:0] seed_value;

    mtbr_in_if  in_ch ();
    mtbr_out_if out_ch ();

    mersenne_twister_bounded_random_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_we    (seed_we),
        .seed_value (seed_value),
        .in_ch      (in_ch.sink),
        .out_ch     (out_ch.source)
    );

    logic [31:0] mt_words [mtbr_pkg::STATE_WORDS];
    int unsigned mt_pos;
    logic [31:0] bound_queue [$];
    logic [31:0] expected_values [$];
    int          mismatch_count;
    int          result_count;
    int          hold_cycles;
    bit          send_enable;
    int          send_gap;
    int          recv_gap;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic queue_bound(input logic [31:0] b);
        bound_queue.insert(bound_queue.size(), b);
    endtask

    task automatic record_expected(input logic [31:0] v);
        expected_values.insert(expected_values.size(), v);
    endtask

    task automatic seed_model(input logic [31:0] seed);
        mt_words[0] = seed;
        for (int i = 1; i < mtbr_pkg::STATE_WORDS; i++)
            mt_words[i] = mt_words[i - 1] * mtbr_pkg::FILL_MULT;
        mt_pos = mtbr_pkg::STATE_WORDS;
    endtask

    function automatic logic [31:0] temper_word(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & mtbr_pkg::TEMPER_B);
        y = y ^ ((y << 15) & mtbr_pkg::TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    task automatic predict_bounded(input logic [31:0] bound);
        logic [31:0] y;
        logic [31:0] v;
        if (bound == 32'd0)
        begin
            record_expected(32'd0);
            return;
        end
        if (mt_pos >= mtbr_pkg::STATE_WORDS)
        begin
            for (int k = 0; k < mtbr_pkg::STATE_WORDS; k++)
            begin
                y = (mt_words[k] & 32'h80000000)
                    | (mt_words[(k + 1) % mtbr_pkg::STATE_WORDS] & 32'h7fffffff);
                v = mt_words[(k + mtbr_pkg::TWIST_OFFSET) % mtbr_pkg::STATE_WORDS]
                    ^ (y >> 1);
                if (y[0])
                    v = v ^ mtbr_pkg::TWIST_MATRIX;
                mt_words[k] = v;
            end
            mt_pos = 0;
        end
        y = temper_word(mt_words[mt_pos]);
        mt_pos++;
        record_expected(y % bound);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.range_bound <= 32'd0;
            send_gap          = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_bounded(in_ch.range_bound);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (send_enable && bound_queue.size() > 0)
                begin
                    in_ch.valid       <= 1'b1;
                    in_ch.range_bound <= bound_queue.pop_front();
                    send_gap          = pick_gap();
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_gap     = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                result_count++;
                if (expected_values.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h", out_ch.random_value);
                end
                else
                begin
                    logic [31:0] want;
                    want = expected_values.pop_front();
                    if (want !== out_ch.random_value)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("random_value mismatch: expected %h actual %h",
                                     want, out_ch.random_value);
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                recv_gap     = pick_gap();
            end
        end
    end

    task automatic wait_drained();
        @(negedge clk);
        while (bound_queue.size() > 0 || in_ch.valid || expected_values.size() > 0)
            @(negedge clk);
        repeat (tb_mtbr_test_pkg::REQUEST_CYCLES + 8) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        seed_we    <= 1'b1;
        seed_value <= seed;
        @(posedge clk);
        seed_we <= 1'b0;
        seed_model(seed);
        repeat (tb_mtbr_test_pkg::FILL_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] random_bound();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 32'd0;
        if (r < 40)
            return $urandom_range(1, 16);
        if (r < 60)
            return $urandom_range(1, 65535);
        return $urandom();
    endfunction

    initial
    begin
        logic [31:0] seeds [5];
        seeds = '{32'd1, 32'hffffffff, 32'd0, 32'h80000000, 32'h12345678};
        rst_n          = 1'b0;
        seed_we        = 1'b0;
        seed_value     = mtbr_pkg::SEED_RESET;
        mismatch_count = 0;
        result_count   = 0;
        hold_cycles    = 0;
        send_enable    = 1'b1;
        seed_model(mtbr_pkg::SEED_RESET);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes and the zero bound
        queue_bound(32'd0);
        queue_bound(32'd1);
        queue_bound(32'hffffffff);
        queue_bound(32'h80000000);
        queue_bound(32'd0);
        queue_bound(32'd2);
        queue_bound(32'h7fffffff);
        queue_bound(32'h55555555);
        queue_bound(32'haaaaaaaa);
        queue_bound(32'd3);
        for (int i = 0; i < 200; i++)
            queue_bound(random_bound());
        wait_drained();

        // long stall on the receiver while requests keep coming
        hold_cycles = 400;
        for (int i = 0; i < 20; i++)
            queue_bound(random_bound());
        wait_drained();

        for (int s = 0; s < 5; s++)
        begin
            write_seed(seeds[s]);
            for (int i = 0; i < (s == 2 ? 50 : 230); i++)
                queue_bound(random_bound());
            wait_drained();
        end

        // write the reset value back and finish with 200 more random bounds
        write_seed(mtbr_pkg::SEED_RESET);
        for (int i = 0; i < 200; i++)
            queue_bound(random_bound());
        wait_drained();

        $display("ran %0d results over six seeds, zero bound and extreme bounds",
                 result_count);
        if (mismatch_count == 0)
            $display("tb_mersenne_twister_bounded_random_top OK");
        else
            $display("tb_mersenne_twister_bounded_random_top NOT OK");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("timeout");
        $display("tb_mersenne_twister_bounded_random_top NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/mtbr_pkg.sv
src/mtbr_in_if.sv
src/mtbr_out_if.sv
src/mtbr_ram.sv
src/mersenne_twister_bounded_random_top.sv
test/tb_mtbr_channels.sv
test/tb_mersenne_twister_bounded_random_top.sv
